// ----- hw/rtl/fpes_pkg.sv -----
// Shared types, constants and helpers for the flash program/erase sequencer.
// No dependencies; every other file imports this package.
`default_nettype none

package fpes_pkg;

    // Flash geometry
    localparam int FLASH_BYTES = 262144;
    localparam int PAGE_BYTES  = 512;
    localparam int PAGE_COUNT  = FLASH_BYTES / PAGE_BYTES;
    localparam int PAGE_LIMIT  = (PAGE_COUNT > 1024) ? 1024 : PAGE_COUNT;

    // Field widths
    localparam int OPCODE_W = 3;
    localparam int OFFSET_W = 19;
    localparam int LENGTH_W = 19;
    localparam int SECTOR_W = 10;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 18;
    localparam int TAKEN_W  = 3;
    localparam int PAGE_W   = 10;

    // Range check width: holds FLASH_BYTES and the sum of offset and length
    localparam int FLASH_BIT_W = $clog2(FLASH_BYTES) + 1;
    localparam int RANGE_W     = (FLASH_BIT_W > OFFSET_W + 1) ? FLASH_BIT_W : OFFSET_W + 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ_CHECK = 3'd0,
        OP_PROG_CHUNK = 3'd1,
        OP_ERASE_SECT = 3'd2,
        OP_ERASE_ALL  = 3'd3,
        OP_POLL_ERASE = 3'd4,
        OP_PROG_CHECK = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_READ_ERR  = 3'd2,
        ST_PROG_ERR  = 3'd3,
        ST_ERASE_ERR = 3'd4
    } status_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
        logic [SECTOR_W-1:0] sector;
        logic [WORD_W-1:0]   write_bytes;
        logic [WORD_W-1:0]   old_word;
        logic                busy_req;
        logic                fail;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic               issue;
        logic               cmd_erase;
        logic [ADDR_W-1:0]  cmd_address;
        logic [WORD_W-1:0]  cmd_data;
        logic [TAKEN_W-1:0] bytes_taken;
        logic               clear_fail;
        logic               invalidate_cache;
        logic               retry_later;
    } rsp_t;

    // Byte address of a page, folded into the command address field
    function automatic logic [ADDR_W-1:0] page_address(input logic [PAGE_W-1:0] page);
        logic [31:0] product;
        product = 32'(page) * 32'(PAGE_BYTES);
        return product[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fpes_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on fpes_pkg for the payload types.
`default_nettype none

interface fpes_req_if;
    import fpes_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fpes_rsp_if;
    import fpes_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fpes_merge.sv -----
// Byte merge for one program chunk: chunk size and merged word.
// Depends on fpes_pkg.
`default_nettype none

module fpes_merge (
    input  wire logic [1:0]                    offset_low,
    input  wire logic [fpes_pkg::LENGTH_W-1:0] length,
    input  wire logic [fpes_pkg::WORD_W-1:0]   write_bytes,
    input  wire logic [fpes_pkg::WORD_W-1:0]   old_word,
    output logic      [fpes_pkg::WORD_W-1:0]   merged,
    output logic      [fpes_pkg::TAKEN_W-1:0]  chunk
);
    import fpes_pkg::*;

    logic [TAKEN_W-1:0] room;

    // Chunk runs to the end of the aligned word, capped by the byte count
    always_comb
    begin
        room = TAKEN_W'(4) - TAKEN_W'(offset_low);
        if (length < LENGTH_W'(room))
        begin
            chunk = length[TAKEN_W-1:0];
        end
        else
        begin
            chunk = room;
        end
    end

    // Lane j takes source byte (j - offset) mod 4 when that byte is in the chunk
    always_comb
    begin
        logic [1:0] src;
        merged = old_word;
        for (int j = 0; j < 4; j++)
        begin
            src = 2'(j) - offset_low;
            if (TAKEN_W'(src) < chunk)
            begin
                merged[8*j +: 8] = write_bytes[8*src +: 8];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/flash_program_erase_sequencer.sv -----
// Flash program/erase request sequencer: top level.
// A request word is held in the input register, then leaves through the response register as a response word.
// Throughput: one request per cycle; the input register and response register
// form a two-stage pipeline that stalls only when the response side holds off.
// Reset: rst_n clears both valid bits, the erasing flag, the erase-all flag and
// the current page at once; payload registers are not reset.
// Depends on fpes_pkg, fpes_if (fpes_req_if, fpes_rsp_if) and fpes_merge.
`default_nettype none

module flash_program_erase_sequencer (
    input wire logic clk,
    input wire logic rst_n,
    fpes_req_if.sink   req,
    fpes_rsp_if.source rsp
);
    import fpes_pkg::*;

    // Input register stage
    logic s1_valid_reg;
    req_t s1_req_reg;
    logic s1_fire;

    // Response register stage
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    // Erase sequencing state
    logic              erasing_reg;
    logic              erasing_next;
    logic              erase_all_reg;
    logic              erase_all_next;
    logic [PAGE_W-1:0] current_page_reg;
    logic [PAGE_W-1:0] current_page_next;

    // Range check and program merge
    logic [RANGE_W-1:0]  off_ext;
    logic [RANGE_W-1:0]  end_ext;
    logic                in_range;
    logic [WORD_W-1:0]   merged;
    logic [TAKEN_W-1:0]  chunk;
    logic [PAGE_W:0]     next_page_ext;

    // Advance stage 1 into the response register when that register is free
    // or being drained this cycle; take a new request whenever stage 1 moves.
    assign s1_fire   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_req_reg <= req.data;
        end
    end

    // Request lies inside the flash when offset <= size and offset + length <= size
    assign off_ext  = RANGE_W'(s1_req_reg.offset);
    assign end_ext  = off_ext + RANGE_W'(s1_req_reg.length);
    assign in_range = (off_ext <= RANGE_W'(FLASH_BYTES)) && (end_ext <= RANGE_W'(FLASH_BYTES));

    assign next_page_ext = {1'b0, current_page_reg} + (PAGE_W+1)'(1);

    fpes_merge u_merge (
        .offset_low  (s1_req_reg.offset[1:0]),
        .length      (s1_req_reg.length),
        .write_bytes (s1_req_reg.write_bytes),
        .old_word    (s1_req_reg.old_word),
        .merged      (merged),
        .chunk       (chunk)
    );

    // Decode the held request into a response and the next erase state
    always_comb
    begin
        rsp_next          = '0;
        rsp_next.status   = ST_OK;
        erasing_next      = erasing_reg;
        erase_all_next    = erase_all_reg;
        current_page_next = current_page_reg;

        case (s1_req_reg.opcode)
            OP_READ_CHECK:
            begin
                if (erasing_reg)
                begin
                    rsp_next.status = ST_BUSY;
                end
                else if (!in_range)
                begin
                    rsp_next.status = ST_READ_ERR;
                end
            end

            OP_PROG_CHUNK:
            begin
                if (erasing_reg)
                begin
                    rsp_next.status = ST_BUSY;
                end
                else if (!in_range)
                begin
                    rsp_next.status = ST_PROG_ERR;
                end
                else if (s1_req_reg.length == '0)
                begin
                    // Nothing left: finish the program, flush the cache
                    rsp_next.invalidate_cache = 1'b1;
                end
                else
                begin
                    rsp_next.issue       = 1'b1;
                    rsp_next.cmd_erase   = 1'b0;
                    rsp_next.cmd_address = {s1_req_reg.offset[ADDR_W-1:2], 2'b00};
                    rsp_next.cmd_data    = merged;
                    rsp_next.bytes_taken = chunk;
                end
            end

            OP_ERASE_SECT:
            begin
                if (erasing_reg)
                begin
                    rsp_next.status = ST_BUSY;
                end
                else if (32'(s1_req_reg.sector) >= 32'(PAGE_COUNT))
                begin
                    rsp_next.status = ST_ERASE_ERR;
                end
                else
                begin
                    erasing_next         = 1'b1;
                    erase_all_next       = 1'b0;
                    current_page_next    = s1_req_reg.sector;
                    rsp_next.issue       = 1'b1;
                    rsp_next.cmd_erase   = 1'b1;
                    rsp_next.cmd_address = page_address(s1_req_reg.sector);
                end
            end

            OP_ERASE_ALL:
            begin
                if (erasing_reg)
                begin
                    rsp_next.status = ST_BUSY;
                end
                else
                begin
                    // Start at page 0; each finished poll moves one page on
                    erasing_next         = 1'b1;
                    erase_all_next       = 1'b1;
                    current_page_next    = '0;
                    rsp_next.issue       = 1'b1;
                    rsp_next.cmd_erase   = 1'b1;
                    rsp_next.cmd_address = page_address('0);
                end
            end

            OP_POLL_ERASE:
            begin
                if (!erasing_reg)
                begin
                    rsp_next.status = ST_OK;
                end
                else if (s1_req_reg.busy_req)
                begin
                    rsp_next.status      = ST_BUSY;
                    rsp_next.retry_later = 1'b1;
                end
                else if (s1_req_reg.fail)
                begin
                    // Abort the erase and clear the controller's fail flag
                    rsp_next.status     = ST_ERASE_ERR;
                    rsp_next.clear_fail = 1'b1;
                    erasing_next        = 1'b0;
                    erase_all_next      = 1'b0;
                end
                else if (erase_all_reg && (next_page_ext < (PAGE_W+1)'(PAGE_LIMIT)))
                begin
                    current_page_next         = next_page_ext[PAGE_W-1:0];
                    rsp_next.status           = ST_BUSY;
                    rsp_next.issue            = 1'b1;
                    rsp_next.cmd_erase        = 1'b1;
                    rsp_next.cmd_address      = page_address(next_page_ext[PAGE_W-1:0]);
                    rsp_next.invalidate_cache = 1'b1;
                    rsp_next.retry_later      = 1'b1;
                end
                else
                begin
                    // Last page done, or single sector done
                    rsp_next.invalidate_cache = 1'b1;
                    erasing_next              = 1'b0;
                    erase_all_next            = 1'b0;
                end
            end

            OP_PROG_CHECK:
            begin
                if (s1_req_reg.busy_req)
                begin
                    rsp_next.retry_later = 1'b1;
                end
                else if (s1_req_reg.fail)
                begin
                    rsp_next.status           = ST_PROG_ERR;
                    rsp_next.clear_fail       = 1'b1;
                    rsp_next.invalidate_cache = 1'b1;
                end
                else if (s1_req_reg.length == '0)
                begin
                    rsp_next.invalidate_cache = 1'b1;
                end
            end

            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    // Commit state and load the response only when stage 1 advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erasing_reg      <= 1'b0;
            erase_all_reg    <= 1'b0;
            current_page_reg <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                erasing_reg      <= erasing_next;
                erase_all_reg    <= erase_all_next;
                current_page_reg <= current_page_next;
            end
            if (s1_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Erase-all runs only inside an erase
    a_all_in_erase: assert property (@(posedge clk) disable iff (!rst_n)
        erase_all_reg |-> erasing_reg)
        else $error("erase-all flag set while not erasing");

    // Entering an erase always loads a page-erase command into the response register
    a_erase_start_issues: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(erasing_reg) |-> (rsp_valid_reg && rsp_reg.issue && rsp_reg.cmd_erase))
        else $error("erase started without a page-erase command");

    // Current page stays within the erasable page range during an erase
    a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
        erasing_reg |-> (32'(current_page_reg) < 32'(PAGE_LIMIT)))
        else $error("current page beyond page count");

    // A stalled response word does not let stage 1 advance or the state move
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> ($stable(erasing_reg) && $stable(current_page_reg)))
        else $error("erase state changed while response stalled");

    // No command means no command payload
    a_idle_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.issue) |->
            (!rsp_reg.cmd_erase && rsp_reg.cmd_address == '0 && rsp_reg.cmd_data == '0))
        else $error("command fields set without issue");

endmodule

`default_nettype wire
